// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of this block.
// Needs a clk and an active-high rst signal in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored during reset.
`define BRPT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, ignored during reset.
`define BRPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define BRPT_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

// ----- rtl/brpt_pkg.sv -----
// Shared constants for the breath peak rate tracker.
// No dependencies; used by the top level and its checker.
package brpt_pkg;

  localparam int HISTORY_LEN_DEF = 10;
  localparam int APNEA_MS_DEF    = 3000;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0     = 3'd0,
    REG_B1     = 3'd1,
    REG_B2     = 3'd2,
    REG_A1     = 3'd3,
    REG_A2     = 3'd4,
    REG_PEAK   = 3'd5,
    REG_MOTION = 3'd6,
    REG_WET    = 3'd7
  } cfg_reg_t;

  localparam logic signed [31:0] B0_RST   = 32'sd418759;
  localparam logic signed [31:0] B1_RST   = 32'sd0;
  localparam logic signed [31:0] B2_RST   = -32'sd418759;
  localparam logic signed [31:0] A1_RST   = -32'sd2124505574;
  localparam logic signed [31:0] A2_RST   = 32'sd1072882831;
  localparam logic [15:0]        PEAK_RST = 16'd50;
  localparam logic [13:0]        MOT_RST  = 14'd20;
  localparam logic [7:0]         WET_RST  = 8'd100;

  localparam logic [6:0] SCORE_MAX = 7'd100;

endpackage

// ----- rtl/breath_peak_rate_tracker.sv -----
// Breath peak rate tracker: top level with filter, peak, rate, regularity, motion and wetness logic.
// Depends on brpt_pkg.
//
// One sample is taken when the block is idle and gives one result. All products go
// through one shared 25x33 signed multiplier with a registered output and one
// accumulator, driven by a sequencer. A sample without a valid breath interval takes
// the 7 filter products, rounding and the result load. A sample that closes a valid
// interval adds the rate product, a 25-step restoring divider and the regularity
// products, plus the ceiling search for the regularity score, one candidate a cycle.
// in_stall is high from acceptance until the result is loaded into the output register.
module breath_peak_rate_tracker #(
  parameter int HISTORY_LEN = brpt_pkg::HISTORY_LEN_DEF,
  parameter int APNEA_MS    = brpt_pkg::APNEA_MS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [brpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brpt_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [11:0]                   force_head,
  input  logic [11:0]                   force_chest,
  input  logic [11:0]                   force_hip_left,
  input  logic [11:0]                   force_hip_right,
  input  logic [11:0]                   wet_trace_one,
  input  logic [11:0]                   wet_trace_two,
  input  logic [31:0]                   time_ms,
  input  logic                          clear_motion_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    rate_bpm,
  output logic [6:0]                    regularity,
  output logic [15:0]                   apnea_events,
  output logic [15:0]                   motion_count,
  output logic [7:0]                    motion_score,
  output logic [7:0]                    wet_level,
  output logic                          wet_flag,
  output logic                          peak_seen
);
  import brpt_pkg::*;

  localparam int IDX_W = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
  localparam int CNT_W = ($clog2(HISTORY_LEN + 1) > 5) ? $clog2(HISTORY_LEN + 1) : 5;
  localparam int SW    = 13 + IDX_W;
  localparam int QW    = 26 + IDX_W;
  localparam int DW    = 2 * SW;
  localparam int TW    = DW + 14;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FILT, ST_FIN, ST_RMUL, ST_RWAIT, ST_DIV, ST_RDONE,
    ST_SQ, ST_S2, ST_NQ, ST_D, ST_LHS, ST_SRCH, ST_DONE
  } state_t;

  state_t state;

  // configuration
  logic signed [31:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic [15:0] peak_level;
  logic [13:0] motion_limit;
  logic [7:0]  wet_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0      <= B0_RST;
      coef_b1      <= B1_RST;
      coef_b2      <= B2_RST;
      coef_a1      <= A1_RST;
      coef_a2      <= A2_RST;
      peak_level   <= PEAK_RST;
      motion_limit <= MOT_RST;
      wet_limit    <= WET_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_B0:     coef_b0      <= cfg_data;
        REG_B1:     coef_b1      <= cfg_data;
        REG_B2:     coef_b2      <= cfg_data;
        REG_A1:     coef_a1      <= cfg_data;
        REG_A2:     coef_a2      <= cfg_data;
        REG_PEAK:   peak_level   <= cfg_data[15:0];
        REG_MOTION: motion_limit <= cfg_data[13:0];
        REG_WET:    wet_limit    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sample and tracker state
  logic [13:0] sum_r, in_hist_one, in_hist_two, prev_force_sum;
  logic [31:0] time_r, last_peak_ms;
  logic        clr_r;
  logic [7:0]  wet_r;
  logic        wet_flag_r;
  logic signed [47:0] out_hist_one, out_hist_two;
  logic [7:0]  rate_reg;
  logic [12:0] ring [HISTORY_LEN];
  logic [IDX_W-1:0] ring_pos;
  logic [15:0] apnea_reg, motion_count_reg;
  logic [7:0]  motion_score_reg;
  logic [6:0]  score_reg;
  logic        peak_r;

  // shared unit
  logic signed [24:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [57:0] prod;
  logic signed [81:0] acc;
  logic signed [81:0] prod_ext;
  logic [4:0]         acc_sh;

  logic [CNT_W-1:0] cnt;
  logic [12:0] iv_r;
  logic [24:0] dnum;
  logic [16:0] dden;
  logic [16:0] drem;
  logic [SW-1:0] s_sum;
  logic [QW-1:0] q_r;
  logic [DW-1:0] s2_r, d_r;
  logic [TW-1:0] t_r, inc_r;
  logic [6:0]    k_r;

  function automatic logic [4:0] term_shift(input logic [CNT_W-1:0] t);
    case (t)
      0, 1, 2: term_shift = 5'd16;
      4, 6:    term_shift = 5'd24;
      default: term_shift = 5'd0;
    endcase
  endfunction

  logic [IDX_W-1:0] sq_idx;
  assign sq_idx = (cnt < CNT_W'(HISTORY_LEN)) ? cnt[IDX_W-1:0] : '0;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    acc_sh = 5'd0;
    case (state)
      ST_FILT: begin
        acc_sh = term_shift(cnt - CNT_W'(1));
        case (cnt)
          0: begin mul_a = 25'(sum_r);       mul_b = 33'(coef_b0); end
          1: begin mul_a = 25'(in_hist_one); mul_b = 33'(coef_b1); end
          2: begin mul_a = 25'(in_hist_two); mul_b = 33'(coef_b2); end
          3: begin mul_a = $signed({1'b0, out_hist_one[23:0]}); mul_b = -33'(coef_a1); end
          4: begin mul_a = 25'($signed(out_hist_one[47:24]));   mul_b = -33'(coef_a1); end
          5: begin mul_a = $signed({1'b0, out_hist_two[23:0]}); mul_b = -33'(coef_a2); end
          6: begin mul_a = 25'($signed(out_hist_two[47:24]));   mul_b = -33'(coef_a2); end
          default: ;
        endcase
      end
      ST_RMUL: begin
        mul_a = $signed(25'(iv_r));
        mul_b = $signed(33'(rate_reg));
      end
      ST_SQ: begin
        mul_a = $signed(25'(ring[sq_idx]));
        mul_b = $signed(33'(ring[sq_idx]));
      end
      ST_S2: begin
        mul_a = $signed(25'(s_sum));
        mul_b = $signed(33'(s_sum));
      end
      ST_NQ: begin
        mul_a = 25'(HISTORY_LEN);
        mul_b = $signed(33'(q_r));
      end
      ST_LHS: begin
        acc_sh = (cnt == CNT_W'(2)) ? 5'd24 : 5'd0;
        mul_b  = 33'sd10000;
        if (cnt == CNT_W'(0)) mul_a = $signed({1'b0, d_r[23:0]});
        else                  mul_a = $signed(25'(d_r[DW-1:24]));
      end
      default: ;
    endcase
  end

  assign prod_ext = 82'(prod);

  // filter rounding and saturation
  logic signed [81:0] rnd, shv;
  logic signed [47:0] y;
  logic               y_fits;
  assign rnd    = acc + (82'sd1 <<< 29);
  assign shv    = rnd >>> 30;
  assign y_fits = (shv[81:47] == {35{shv[47]}});
  always_comb begin
    if (y_fits)      y = shv[47:0];
    else if (shv[81]) y = {1'b1, 47'b0};
    else             y = {1'b0, {47{1'b1}}};
  end

  logic        peak;
  logic [31:0] iv;
  logic        iv_ok;
  logic [13:0] delta;
  logic [15:0] mc_base;
  assign peak  = (out_hist_two < out_hist_one) && (out_hist_one > y)
              && (out_hist_one > $signed({16'b0, peak_level, 16'b0}));
  assign iv    = time_r - last_peak_ms;
  assign iv_ok = (iv > 32'd500) && (iv < 32'd5000) && (last_peak_ms != 32'd0);
  assign delta = (sum_r > prev_force_sum) ? sum_r - prev_force_sum : prev_force_sum - sum_r;
  assign mc_base = clr_r ? 16'd0 : motion_count_reg;

  // divider set-up from the interval and the rate product
  logic [20:0] rp;
  logic [24:0] num_calc;
  logic [16:0] den_calc;
  assign rp = prod[20:0];
  always_comb begin
    if (rate_reg == 8'd0) begin
      num_calc = 25'd120000 + 25'(iv_r);
      den_calc = {3'b0, iv_r, 1'b0};
    end else begin
      num_calc = (25'(rp) << 4) - (25'(rp) << 1) + 25'd360000
               + (25'(iv_r) << 3) + (25'(iv_r) << 1);
      den_calc = (17'(iv_r) << 4) + (17'(iv_r) << 2);
    end
  end

  logic [17:0] trial;
  logic        trial_ge;
  assign trial    = {drem, dnum[24]};
  assign trial_ge = trial >= {1'b0, dden};

  logic [DW-1:0] nq_v;
  assign nq_v = prod[DW-1:0];

  logic [TW-1:0] lhs;
  assign lhs = acc[TW-1:0];

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      in_hist_one      <= '0;
      in_hist_two      <= '0;
      out_hist_one     <= '0;
      out_hist_two     <= '0;
      last_peak_ms     <= '0;
      rate_reg         <= '0;
      for (int i = 0; i < HISTORY_LEN; i++) ring[i] <= '0;
      ring_pos         <= '0;
      apnea_reg        <= '0;
      motion_count_reg <= '0;
      motion_score_reg <= '0;
      prev_force_sum   <= '0;
      score_reg        <= '0;
      cnt              <= '0;
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            sum_r <= 14'(force_head) + 14'(force_chest)
                   + 14'(force_hip_left) + 14'(force_hip_right);
            wet_r      <= 8'((13'(wet_trace_one) + 13'(wet_trace_two)) >> 5);
            wet_flag_r <= 8'((13'(wet_trace_one) + 13'(wet_trace_two)) >> 5) > wet_limit;
            time_r     <= time_ms;
            clr_r      <= clear_motion_count;
            cnt        <= '0;
            state      <= ST_FILT;
          end
        end
        ST_FILT: begin
          if (cnt == CNT_W'(1)) acc <= prod_ext <<< acc_sh;
          else if (cnt != '0)   acc <= acc + (prod_ext <<< acc_sh);
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(7)) state <= ST_FIN;
        end
        ST_FIN: begin
          peak_r       <= peak;
          in_hist_two  <= in_hist_one;
          in_hist_one  <= sum_r;
          out_hist_two <= out_hist_one;
          out_hist_one <= y;
          prev_force_sum <= sum_r;
          if (delta > motion_limit) begin
            motion_count_reg <= mc_base + 16'd1;
            motion_score_reg <= (delta > 14'd255) ? 8'd255 : delta[7:0];
          end else begin
            motion_count_reg <= mc_base;
          end
          state <= ST_DONE;
          if (peak) begin
            last_peak_ms <= time_r;
            if (iv_ok) begin
              iv_r <= iv[12:0];
              if (iv > 32'(APNEA_MS)) apnea_reg <= apnea_reg + 16'd1;
              state <= ST_RMUL;
            end
          end
        end
        ST_RMUL: state <= ST_RWAIT;
        ST_RWAIT: begin
          dnum  <= num_calc;
          dden  <= den_calc;
          drem  <= '0;
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          // one quotient bit per cycle, quotient shifts into dnum
          drem <= trial_ge ? 17'(trial - {1'b0, dden}) : trial[16:0];
          dnum <= {dnum[23:0], trial_ge};
          cnt  <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(24)) state <= ST_RDONE;
        end
        ST_RDONE: begin
          rate_reg       <= (dnum > 25'd255) ? 8'd255 : dnum[7:0];
          ring[ring_pos] <= iv_r;
          ring_pos       <= (ring_pos == IDX_W'(HISTORY_LEN - 1)) ? '0
                                                                  : ring_pos + IDX_W'(1);
          s_sum <= '0;
          cnt   <= '0;
          state <= ST_SQ;
        end
        ST_SQ: begin
          if (cnt < CNT_W'(HISTORY_LEN)) s_sum <= s_sum + SW'(ring[sq_idx]);
          if (cnt == CNT_W'(1))  acc <= prod_ext;
          else if (cnt != '0)    acc <= acc + prod_ext;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(HISTORY_LEN)) state <= ST_S2;
        end
        ST_S2: begin
          q_r   <= acc[QW-1:0];
          state <= ST_NQ;
        end
        ST_NQ: begin
          s2_r  <= prod[DW-1:0];
          state <= ST_D;
        end
        ST_D: begin
          d_r   <= (nq_v > s2_r) ? nq_v - s2_r : '0;
          cnt   <= '0;
          state <= ST_LHS;
        end
        ST_LHS: begin
          if (cnt == CNT_W'(1))      acc <= prod_ext;
          else if (cnt == CNT_W'(2)) acc <= acc + (prod_ext <<< acc_sh);
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(2)) begin
            t_r   <= '0;
            inc_r <= TW'(s2_r);
            k_r   <= '0;
            state <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          // advance k until 10000*D <= k^2 * S^2
          if (s_sum == '0) begin
            score_reg <= '0;
            state     <= ST_DONE;
          end else if (k_r == SCORE_MAX || lhs <= t_r) begin
            score_reg <= SCORE_MAX - k_r;
            state     <= ST_DONE;
          end else begin
            t_r   <= t_r + inc_r;
            inc_r <= inc_r + (TW'(s2_r) << 1);
            k_r   <= k_r + 7'd1;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            rate_bpm     <= rate_reg;
            regularity   <= score_reg;
            apnea_events <= apnea_reg;
            motion_count <= motion_count_reg;
            motion_score <= motion_score_reg;
            wet_level    <= wet_r;
            wet_flag     <= wet_flag_r;
            peak_seen    <= peak_r;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/brpt_checker.sv -----
// Port-level checker for the breath peak rate tracker, bound to the top level.
// Depends on brpt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module brpt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] regularity
);
  import brpt_pkg::*;

  // an accepted request keeps the block busy on the next cycle
  `BRPT_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
  // a waiting result stays offered
  `BRPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(regularity))
  `BRPT_ASSERT_NOW(a_score_range, out_valid, regularity <= SCORE_MAX)
  // reset leaves the block empty and ready
  `BRPT_ASSERT_ALWAYS(a_reset_clear, rst, !out_valid && !in_stall)

endmodule

bind breath_peak_rate_tracker brpt_checker u_brpt_checker (.*);

// ----- sim/breath_peak_rate_tracker_test.sv -----
// Self-checking bench for breath_peak_rate_tracker: drives force/wetness samples,
// predicts each result in a scoreboard class and compares field by field.
// Depends on brpt_pkg and the breath_peak_rate_tracker RTL.
`timescale 1ns / 1ps

module breath_peak_rate_tracker_test;
  import brpt_pkg::*;

  typedef struct {
    logic [11:0] force_head, force_chest, force_hip_left, force_hip_right;
    logic [11:0] wet_trace_one, wet_trace_two;
    logic [31:0] stamp;
    logic        clear_motion_count;
  } sample_t;

  typedef struct {
    logic [7:0]  rate_bpm;
    logic [6:0]  regularity;
    logic [15:0] apnea_events, motion_count;
    logic [7:0]  motion_score, wet_level;
    logic        wet_flag, peak_seen;
  } vitals_t;

  class vitals_scoreboard;
    logic signed [31:0] b0, b1, b2, a1, a2;
    logic [15:0] peak_level;
    logic [13:0] motion_limit;
    logic [7:0]  wet_limit;
    logic [14:0] sum_one, sum_two, prev_sum;
    logic signed [47:0] y_one, y_two;
    logic [31:0] last_peak_ms;
    logic [7:0]  rate;
    logic [12:0] ring[HISTORY_LEN_DEF];
    int          ring_pos;
    logic [15:0] apnea, motions;
    logic [7:0]  motion_score;
    vitals_t     pending[$];
    int          errors;

    function new();
      b0 = B0_RST; b1 = B1_RST; b2 = B2_RST; a1 = A1_RST; a2 = A2_RST;
      peak_level = PEAK_RST; motion_limit = MOT_RST; wet_limit = WET_RST;
      sum_one = 0; sum_two = 0; prev_sum = 0; y_one = 0; y_two = 0;
      last_peak_ms = 0; rate = 0; ring_pos = 0; apnea = 0; motions = 0;
      motion_score = 0; errors = 0;
      foreach (ring[i]) ring[i] = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] data);
      case (idx)
        REG_B0:     b0 = data;
        REG_B1:     b1 = data;
        REG_B2:     b2 = data;
        REG_A1:     a1 = data;
        REG_A2:     a2 = data;
        REG_PEAK:   peak_level = data[15:0];
        REG_MOTION: motion_limit = data[13:0];
        REG_WET:    wet_limit = data[7:0];
        default: ;
      endcase
    endfunction

    function logic signed [47:0] filter(logic [14:0] sum);
      logic signed [127:0] acc, v, c, hi_lim, lo_lim;
      hi_lim = (128'sd1 <<< 47) - 1;
      lo_lim = -(128'sd1 <<< 47);
      v = sum;     c = b0; acc = (v <<< 16) * c;
      v = sum_one; c = b1; acc = acc + (v <<< 16) * c;
      v = sum_two; c = b2; acc = acc + (v <<< 16) * c;
      v = y_one;   c = a1; acc = acc - v * c;
      v = y_two;   c = a2; acc = acc - v * c;
      acc = (acc + (128'sd1 <<< 29)) >>> 30;
      if (acc > hi_lim) acc = hi_lim;
      if (acc < lo_lim) acc = lo_lim;
      return acc[47:0];
    endfunction

    function logic [6:0] regularity_score();
      longint unsigned s, q, d, s2, lhs;
      int k;
      s = 0; q = 0;
      foreach (ring[i]) begin
        s += ring[i];
        q += longint'(ring[i]) * ring[i];
      end
      if (s == 0) return 0;
      s2 = s * s;
      d = HISTORY_LEN_DEF * q;
      d = (d > s2) ? d - s2 : 0;
      lhs = 10000 * d;
      for (k = 0; k < 100; k++)
        if (lhs <= longint'(k) * k * s2) break;
      return 7'(100 - k);
    endfunction

    function void note_request(sample_t smp);
      logic [14:0] sum, delta;
      logic [12:0] wsum;
      logic signed [47:0] y;
      logic signed [63:0] thr;
      logic [31:0] iv;
      longint unsigned r;
      logic peak;
      vitals_t res;
      sum = 15'(smp.force_head) + smp.force_chest + smp.force_hip_left + smp.force_hip_right;
      wsum = 13'(smp.wet_trace_one) + smp.wet_trace_two;
      y = filter(sum);
      thr = peak_level;
      thr = thr <<< 16;
      peak = (y_two < y_one) && (y_one > y) && (y_one > thr);
      if (smp.clear_motion_count) motions = 0;
      if (peak) begin
        iv = smp.stamp - last_peak_ms;
        if (iv > 500 && iv < 5000 && last_peak_ms != 0) begin
          if (rate == 0) r = (120000 + longint'(iv)) / (2 * longint'(iv));
          else r = (2 * (7 * longint'(rate) * iv + 180000) + 10 * longint'(iv))
                   / (20 * longint'(iv));
          rate = (r > 255) ? 8'd255 : 8'(r);
          ring[ring_pos] = iv[12:0];
          ring_pos = (ring_pos + 1) % HISTORY_LEN_DEF;
          if (iv > APNEA_MS_DEF) apnea++;
        end
        last_peak_ms = smp.stamp;
      end
      sum_two = sum_one; sum_one = sum;
      y_two = y_one; y_one = y;
      delta = (sum > prev_sum) ? sum - prev_sum : prev_sum - sum;
      if (delta > motion_limit) begin
        motions++;
        motion_score = (delta > 255) ? 8'd255 : 8'(delta);
      end
      prev_sum = sum;
      res.rate_bpm = rate;
      res.regularity = regularity_score();
      res.apnea_events = apnea;
      res.motion_count = motions;
      res.motion_score = motion_score;
      res.wet_level = 8'(wsum >> 5);
      res.wet_flag = res.wet_level > wet_limit;
      res.peak_seen = peak;
      pending.push_back(res);
    endfunction

    function void check_result(vitals_t got);
      vitals_t exp;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.rate_bpm !== exp.rate_bpm) begin
        $error("rate_bpm expected %0d got %0d", exp.rate_bpm, got.rate_bpm); errors++;
      end
      if (got.regularity !== exp.regularity) begin
        $error("regularity expected %0d got %0d", exp.regularity, got.regularity); errors++;
      end
      if (got.apnea_events !== exp.apnea_events) begin
        $error("apnea_events expected %0d got %0d", exp.apnea_events, got.apnea_events);
        errors++;
      end
      if (got.motion_count !== exp.motion_count) begin
        $error("motion_count expected %0d got %0d", exp.motion_count, got.motion_count);
        errors++;
      end
      if (got.motion_score !== exp.motion_score) begin
        $error("motion_score expected %0d got %0d", exp.motion_score, got.motion_score);
        errors++;
      end
      if (got.wet_level !== exp.wet_level) begin
        $error("wet_level expected %0d got %0d", exp.wet_level, got.wet_level); errors++;
      end
      if (got.wet_flag !== exp.wet_flag) begin
        $error("wet_flag expected %0d got %0d", exp.wet_flag, got.wet_flag); errors++;
      end
      if (got.peak_seen !== exp.peak_seen) begin
        $error("peak_seen expected %0d got %0d", exp.peak_seen, got.peak_seen); errors++;
      end
    endfunction
  endclass

  logic        clk = 0, rst = 1;
  logic        cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic        in_valid = 0, in_stall;
  logic [11:0] force_head = 0, force_chest = 0, force_hip_left = 0, force_hip_right = 0;
  logic [11:0] wet_trace_one = 0, wet_trace_two = 0;
  logic [31:0] time_ms = 0;
  logic        clear_motion_count = 0;
  logic        out_valid, out_stall = 0;
  logic [7:0]  rate_bpm, motion_score, wet_level;
  logic [6:0]  regularity;
  logic [15:0] apnea_events, motion_count;
  logic        wet_flag, peak_seen;

  vitals_scoreboard sb = new();
  int          idle_pct = 0, stall_pct = 0;
  int          sent = 0;
  logic [31:0] now_ms = 1000;

  breath_peak_rate_tracker dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    vitals_t got;
    if (!rst && out_valid && !out_stall) begin
      got.rate_bpm = rate_bpm;         got.regularity = regularity;
      got.apnea_events = apnea_events; got.motion_count = motion_count;
      got.motion_score = motion_score; got.wet_level = wet_level;
      got.wet_flag = wet_flag;         got.peak_seen = peak_seen;
      sb.check_result(got);
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_sample(sample_t smp);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1;
    force_head <= smp.force_head;         force_chest <= smp.force_chest;
    force_hip_left <= smp.force_hip_left; force_hip_right <= smp.force_hip_right;
    wet_trace_one <= smp.wet_trace_one;   wet_trace_two <= smp.wet_trace_two;
    time_ms <= smp.stamp;                 clear_motion_count <= smp.clear_motion_count;
    do @(posedge clk); while (in_stall);
    sb.note_request(smp);
    sent++;
  endtask

  // Spread a force sum over the four channels; wetness and clear are random.
  task automatic send_sum(int sum, int dt);
    sample_t smp;
    smp.force_head = 12'(sum / 4 + (sum % 4 > 0));
    smp.force_chest = 12'(sum / 4 + (sum % 4 > 1));
    smp.force_hip_left = 12'(sum / 4 + (sum % 4 > 2));
    smp.force_hip_right = 12'(sum / 4);
    smp.wet_trace_one = 12'($urandom);
    smp.wet_trace_two = 12'($urandom);
    smp.clear_motion_count = ($urandom_range(9) == 0);
    now_ms += dt;
    smp.stamp = now_ms;
    send_sample(smp);
  endtask

  task automatic send_noise();
    sample_t smp;
    smp.force_head = 12'($urandom);     smp.force_chest = 12'($urandom);
    smp.force_hip_left = 12'($urandom); smp.force_hip_right = 12'($urandom);
    smp.wet_trace_one = 12'($urandom);  smp.wet_trace_two = 12'($urandom);
    smp.clear_motion_count = ($urandom_range(9) == 0);
    if ($urandom_range(19) == 0) now_ms = $urandom;
    else now_ms += $urandom_range(0, 300);
    smp.stamp = now_ms;
    send_sample(smp);
  endtask

  // One breath: ramp up to a crest above the given level, then down; the
  // whole breath spans period_ms so crests repeat at that interval.
  task automatic breathe(int period_ms, int level);
    int n, base, crest, dt, s;
    n = $urandom_range(2, 4);
    base = $urandom_range(0, (level < 2000) ? level : 2000);
    crest = (level >= 16379) ? 16380 : $urandom_range(level + 1, 16380);
    dt = period_ms / (2 * n);
    for (int i = 0; i < 2 * n; i++) begin
      s = (i <= n) ? base + (crest - base) * i / n : base + (crest - base) * (2 * n - i) / n;
      send_sum(s, (i == 2 * n - 1) ? period_ms - dt * (2 * n - 1) : dt);
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, data);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 79; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 79; end
      default: begin idle_pct = 25; stall_pct = 25; end
    endcase
  endtask

  initial begin
    sample_t smp;
    int level, period, kind;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: field extremes, wet threshold edges, clear, timestamp ends.
    smp = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 1'b0};
    send_sample(smp);
    smp = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 1'b1};
    send_sample(smp);
    smp = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd1600, 12'd1600, 32'd5, 1'b0};
    send_sample(smp);
    smp = '{12'd5, 12'd0, 12'd0, 12'd0, 12'd1616, 12'd1616, 32'd10, 1'b1};
    send_sample(smp);
    smp = '{12'd300, 12'd0, 12'd0, 12'd0, 12'd1, 12'd0, 32'd20, 1'b0};
    send_sample(smp);
    drain();

    // Unity-gain filter: interval edges around 500, 5000 and the apnea limit.
    write_reg(REG_B0, 32'h4000_0000);
    write_reg(REG_B1, 32'd0);
    write_reg(REG_B2, 32'd0);
    write_reg(REG_A1, 32'd0);
    write_reg(REG_A2, 32'd0);
    write_reg(REG_PEAK, 32'hFFFF_0064);
    now_ms = 2000;
    breathe(1000, 100);
    breathe(500, 100);
    breathe(501, 100);
    breathe(4999, 100);
    breathe(5000, 100);
    breathe(3000, 100);
    breathe(3001, 100);
    drain();

    for (int phase = 0; sent < 1250; phase++) begin
      set_idling(phase);
      kind = phase % 6;
      level = (kind == 1) ? 0 : $urandom_range(0, 3000);
      if (kind == 5) begin
        // Extreme coefficients drive the filter into saturation.
        write_reg(REG_B0, $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000);
        write_reg(REG_B1, $urandom);
        write_reg(REG_B2, $urandom);
        write_reg(REG_A1, $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
        write_reg(REG_A2, $urandom);
      end else if (kind == 3) begin
        write_reg(REG_B0, B0_RST);
        write_reg(REG_B1, B1_RST);
        write_reg(REG_B2, B2_RST);
        write_reg(REG_A1, A1_RST);
        write_reg(REG_A2, A2_RST);
      end else begin
        write_reg(REG_B0, 32'h4000_0000);
        write_reg(REG_B1, 32'd0);
        write_reg(REG_B2, 32'd0);
        write_reg(REG_A1, 32'd0);
        write_reg(REG_A2, 32'd0);
      end
      case (kind)
        4: begin
          write_reg(REG_PEAK, 32'h0000_FFFF);
          write_reg(REG_MOTION, {18'($urandom_range(0, 3)), 14'd16380});
          write_reg(REG_WET, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(REG_PEAK, {16'($urandom_range(0, 65535)), 16'd0});
          write_reg(REG_MOTION, 32'd0);
          write_reg(REG_WET, 32'd0);
        end
        default: begin
          write_reg(REG_PEAK, {16'($urandom), 16'(level)});
          write_reg(REG_MOTION, {18'($urandom), 14'($urandom_range(0, 16380))});
          write_reg(REG_WET, {24'($urandom), 8'($urandom)});
        end
      endcase
      if (kind == 2) now_ms = 32'hFFFF_F000 - $urandom_range(0, 20000);
      period = $urandom_range(520, 4980);
      for (int n = 0; n < 110 && sent < 1250; ) begin
        if (kind == 3 || kind == 5 || $urandom_range(9) == 0) begin
          send_noise();
          n++;
        end else begin
          if ((phase & 1) && $urandom_range(3) != 0) ;
          else if ($urandom_range(9) == 0) period = $urandom_range(0, 1) ?
              $urandom_range(50, 500) : $urandom_range(5000, 7000);
          else period = $urandom_range(520, 4980);
          breathe(period, (kind == 4) ? 16379 : level);
          n += 6;
        end
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
